>>> rtl/core/bra_pkg.sv
// shared types, codes and sizes for the block range allocator
// no dependencies; imported by every module of the allocator
`default_nettype none

package bra_pkg;

    // fixed field widths of the request and result beats
    localparam int TYPE_W  = 2;
    localparam int START_W = 8;
    localparam int COUNT_W = 9;
    localparam int VALUE_W = 32;

    // default store size
    localparam int NUM_CELLS_DEF = 256;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [TYPE_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_CHECK,
        ST_RESP
    } state_t;

    // classified request, as queued between front and back
    typedef struct packed {
        op_t                op;
        logic               fail;
        logic [START_W-1:0] first;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    // queue status seen by front and back
    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/bra_front.sv
// request front end: decodes the request type and checks the range bounds
// depends on bra_pkg; feeds the command queue
`default_nettype none

module bra_front
    import bra_pkg::*;
#(
    parameter int NUM_CELLS = NUM_CELLS_DEF
) (
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [TYPE_W-1:0]         req_type,
    input  wire logic [START_W-1:0]        start_index,
    input  wire logic [COUNT_W-1:0]        cell_count,
    input  wire logic signed [VALUE_W-1:0] write_value,
    input  wire q_stat_t                   q_stat,
    output logic                           push,
    output cmd_t                           cmd
);

    localparam int CNT_W = $clog2(NUM_CELLS + 1);
    localparam int SUM_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

    logic [SUM_W-1:0] range_end;
    logic [SUM_W-1:0] limit;
    logic             walk_bad;
    logic             cell_bad;
    op_t              op;

    assign op        = op_t'(req_type);
    assign limit     = SUM_W'(NUM_CELLS);
    assign range_end = SUM_W'(start_index) + SUM_W'(cell_count);
    assign walk_bad  = (range_end > limit);
    assign cell_bad  = (SUM_W'(start_index) >= limit);

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    always_comb
    begin
        cmd.op    = op;
        cmd.first = start_index;
        cmd.count = cell_count;
        cmd.value = write_value;
        unique case (op)
            OP_ALLOC, OP_FREE: cmd.fail = walk_bad;
            OP_READ, OP_WRITE: cmd.fail = cell_bad;
            default:           cmd.fail = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/bra_queue.sv
// short command queue between front and back
// depends on bra_pkg for the command type and depth
`default_nettype none

module bra_queue
    import bra_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head_cmd,
    output q_stat_t   q_stat
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    assign q_stat.valid = (cnt_reg != '0);
    assign q_stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

>>> rtl/core/bra_back.sv
// execution back end: owns the cell store, walks ranges one cell a cycle
// and holds the result beat; depends on bra_pkg
`default_nettype none

module bra_back
    import bra_pkg::*;
#(
    parameter int NUM_CELLS = NUM_CELLS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire q_stat_t              q_stat,
    input  wire cmd_t                 cmd,
    output logic                      pop,
    output logic                      clearing,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      success,
    output logic signed [VALUE_W-1:0] read_value
);

    localparam int IDX_W = $clog2(NUM_CELLS);

    // cell store, registered read port
    logic [VALUE_W-1:0] cell_mem [NUM_CELLS];
    logic [VALUE_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   clr_reg;
    logic [IDX_W-1:0]   clr_next;
    logic [IDX_W-1:0]   cur_reg;
    logic [IDX_W-1:0]   cur_next;
    logic [COUNT_W-1:0] left_reg;
    logic [COUNT_W-1:0] left_next;
    op_t                op_reg;
    op_t                op_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               res_ok_reg;
    logic               res_ok_next;
    logic [VALUE_W-1:0] res_val_reg;
    logic [VALUE_W-1:0] res_val_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_ok_reg;
    logic [VALUE_W-1:0] out_val_reg;

    logic               walk_op;
    logic               walk_hit;
    logic               walk_stop;
    logic               out_free;
    logic               out_load;

    assign walk_op   = (cmd.op == OP_ALLOC) || (cmd.op == OP_FREE);
    // alloc stops on a used cell, free on a free one
    assign walk_hit  = (op_reg == OP_ALLOC) ? (rd_data_reg != '0) : (rd_data_reg == '0);
    assign walk_stop = walk_hit || (left_reg == COUNT_W'(1));
    assign out_free  = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == IDX_W'(NUM_CELLS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_stat.valid)
                begin
                    if (cmd.fail || (walk_op && (cmd.count == '0)))
                        state_next = ST_RESP;
                    else if (walk_op)
                        state_next = ST_WALK;
                    else
                        state_next = ST_CHECK;
                end
            ST_WALK:
                if (walk_stop)
                    state_next = ST_RESP;
            ST_CHECK:
                state_next = ST_RESP;
            ST_RESP:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        pop          = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = cur_reg;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = cur_reg + 1'b1;
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        left_next    = left_reg;
        op_next      = op_reg;
        value_next   = value_reg;
        res_ok_next  = res_ok_reg;
        res_val_next = res_val_reg;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            ST_IDLE:
                if (q_stat.valid)
                begin
                    pop          = 1'b1;
                    op_next      = cmd.op;
                    cur_next     = IDX_W'(cmd.first);
                    left_next    = cmd.count;
                    value_next   = cmd.value;
                    res_ok_next  = !cmd.fail;
                    res_val_next = '0;
                    mem_re       = !cmd.fail;
                    mem_raddr    = IDX_W'(cmd.first);
                end
            ST_WALK:
            begin
                mem_we    = !walk_hit;
                mem_waddr = cur_reg;
                mem_wdata = (op_reg == OP_ALLOC) ? VALUE_W'(1) : '0;
                if (walk_stop)
                    res_ok_next = !walk_hit;
                else
                begin
                    // prefetch the next cell while this one is written
                    mem_re    = 1'b1;
                    mem_raddr = cur_reg + 1'b1;
                    cur_next  = cur_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                end
            end
            ST_CHECK:
                if (rd_data_reg != '0)
                begin
                    res_ok_next = 1'b1;
                    if (op_reg == OP_READ)
                        res_val_next = rd_data_reg;
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_reg;
                        mem_wdata = value_reg;
                    end
                end
                else
                    res_ok_next = 1'b0;
            ST_RESP:
                out_load = out_free;
            default:
                out_load = 1'b0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        left_reg    <= left_next;
        op_reg      <= op_next;
        value_reg   <= value_next;
        res_ok_reg  <= res_ok_next;
        res_val_reg <= res_val_next;
        if (out_load)
        begin
            out_ok_reg  <= res_ok_reg;
            out_val_reg <= res_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rd_data_reg <= cell_mem[mem_raddr];
    end

    assign clearing   = (state_reg == ST_CLEAR);
    assign out_valid  = out_valid_reg;
    assign success    = out_ok_reg;
    assign read_value = out_val_reg;

endmodule

`default_nettype wire

>>> rtl/core/block_range_allocator_top.sv
// top level of the block range allocator: front, command queue, back
// depends on bra_pkg, bra_front, bra_queue and bra_back
// the back serves one request at a time, walking an allocate/free range one cell a cycle;
// read/write checks one cell; a failed or zero-count range goes straight to the result;
// the command queue keeps accepting request beats meanwhile until it is full
// reset: after rst_n the back clears the store; up to two request beats are
// queued meanwhile, results start after the clear pass
`default_nettype none

module block_range_allocator_top
    import bra_pkg::*;
#(
    parameter int NUM_CELLS = NUM_CELLS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    // request channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [TYPE_W-1:0]         req_type,
    input  wire logic [START_W-1:0]        start_index,
    input  wire logic [COUNT_W-1:0]        cell_count,
    input  wire logic signed [VALUE_W-1:0] write_value,

    // result channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           success,
    output logic signed [VALUE_W-1:0]      read_value
);

    // front to queue
    logic    push;
    cmd_t    push_cmd;

    // queue to back
    cmd_t    head_cmd;
    q_stat_t q_stat;
    logic    pop;

    // back is sweeping the store after reset
    logic    clearing;

    // decode and bound check; stalls only on a full queue
    bra_front #(
        .NUM_CELLS (NUM_CELLS)
    ) u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .start_index (start_index),
        .cell_count  (cell_count),
        .write_value (write_value),
        .q_stat      (q_stat),
        .push        (push),
        .cmd         (push_cmd)
    );

    // decouples acceptance from execution
    bra_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    // store owner: clear pass, range walk, cell check, result register
    bra_back #(
        .NUM_CELLS (NUM_CELLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .cmd        (head_cmd),
        .pop        (pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .success    (success),
        .read_value (read_value)
    );

    // a failed beat never carries data
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !success) |-> (read_value == '0))
        else $error("failed result with nonzero read_value");

    // no result can appear while the store is still being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid)
        else $error("result beat during clear pass");

    // an accepted request beat is held in the queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> q_stat.valid)
        else $error("accepted request beat lost by the queue");

endmodule

`default_nettype wire
